// File: src/afsp_pkg.sv
`default_nettype none
package afsp_pkg;

	localparam int WordW    = 32;
	localparam int ThrW     = 16;
	localparam int ChanW    = 8;
	localparam int CountW   = 16;
	localparam int IndexW   = CountW + 1;
	localparam int SampleW  = 16;
	localparam int KindW    = 2;
	localparam int ClassW   = 2;
	localparam int CfgIdxW  = 1;
	localparam int PhaseW   = 3;

	localparam logic [WordW-1:0] EventEndWord = 32'hfafafafa;
	localparam logic [WordW-1:0] DataEndWord  = 32'hf000f000;

	localparam logic [ThrW-1:0] LowThrReset  = 16'd1200;
	localparam logic [ThrW-1:0] HighThrReset = 16'd3000;

	localparam logic [CfgIdxW-1:0] RegLowThr  = 1'd0;
	localparam logic [CfgIdxW-1:0] RegHighThr = 1'd1;

	localparam logic [PhaseW-1:0] PhFrame  = 3'd0;
	localparam logic [PhaseW-1:0] PhHeader = 3'd1;
	localparam logic [PhaseW-1:0] PhCount  = 3'd2;
	localparam logic [PhaseW-1:0] PhData   = 3'd3;
	localparam logic [PhaseW-1:0] PhEoe    = 3'd4;

	localparam logic [KindW-1:0] KindSample  = 2'd0;
	localparam logic [KindW-1:0] KindEoeOk   = 2'd1;
	localparam logic [KindW-1:0] KindEoeBad  = 2'd2;

	localparam logic [ClassW-1:0] ClsAnalog = 2'd0;
	localparam logic [ClassW-1:0] ClsOne    = 2'd1;
	localparam logic [ClassW-1:0] ClsZero   = 2'd2;

	typedef struct packed {
		logic [KindW-1:0]   result_kind;
		logic [ChanW-1:0]   channel;
		logic [IndexW-1:0]  sample_index;
		logic [SampleW-1:0] sample_value;
		logic [ClassW-1:0]  sample_class;
		logic [WordW-1:0]   bad_word;
		logic               last;
	} result_t;

endpackage
`default_nettype wire

// File: src/afsp_if.sv
`default_nettype none
interface afsp_word_if;
	logic                     valid;
	logic                     ready;
	logic [afsp_pkg::WordW-1:0] word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface afsp_result_if;
	logic                         valid;
	logic                         ready;
	logic [afsp_pkg::KindW-1:0]   result_kind;
	logic [afsp_pkg::ChanW-1:0]   channel;
	logic [afsp_pkg::IndexW-1:0]  sample_index;
	logic [afsp_pkg::SampleW-1:0] sample_value;
	logic [afsp_pkg::ClassW-1:0]  sample_class;
	logic [afsp_pkg::WordW-1:0]   bad_word;
	logic                         last;

	modport source (output valid, output result_kind, output channel, output sample_index,
		output sample_value, output sample_class, output bad_word, output last, input ready);
	modport sink (input valid, input result_kind, input channel, input sample_index,
		input sample_value, input sample_class, input bad_word, input last, output ready);
endinterface
`default_nettype wire

// File: src/adc_frame_stream_parser_core.sv
// channel   direction  content
// in_ch     in         one 32-bit stream word
// out_ch    out        sample or event-end result, last marks the final one of a word
// cfg       in         write enable, register index, 16-bit data
//
// A word is parsed in the cycle it is accepted; its results sit in a two-entry result
// register and show on out_ch from the next cycle. Data words give two results, other
// words at most one. The result register sets the rate: a new word is taken when no
// result is pending, or when the only one left is being taken.
// Reset (arst_n low) clears the parser state and sets the thresholds to 1200 and 3000.
`default_nettype none
module adc_frame_stream_parser_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [afsp_pkg::CfgIdxW-1:0]  cfg_idx,
	input  wire [afsp_pkg::ThrW-1:0]     cfg_data,
	afsp_word_if.sink                    in_ch,
	afsp_result_if.source                out_ch
);
	import afsp_pkg::*;

	logic [ThrW-1:0]   low_thr_q, high_thr_q;
	logic [PhaseW-1:0] phase_q, phase_d;
	logic [ChanW-1:0]  chan_q, chan_d;
	logic [CountW-1:0] count_q, count_d;
	logic [IndexW-1:0] index_q, index_d;

	logic              out_valid_q, have2_q;
	result_t           res0_q, res1_q;
	result_t           r0, r1;
	logic [1:0]        n_res;
	logic              accept, out_take;
	logic [WordW-1:0]  w;
	logic [SampleW-1:0] s_lo, s_hi;

	function automatic logic [ClassW-1:0] classify(input logic [SampleW-1:0] v,
			input logic [ThrW-1:0] lo, input logic [ThrW-1:0] hi);
		logic [ClassW-1:0] c;
		priority if (v < lo) c = ClsOne;
		else if (v > hi)     c = ClsZero;
		else                 c = ClsAnalog;
		return c;
	endfunction

	assign w        = in_ch.word;
	assign s_lo     = w[15:0];
	assign s_hi     = w[31:16];
	assign out_take = out_valid_q && out_ch.ready;
	assign in_ch.ready = !out_valid_q || (out_ch.ready && !have2_q);
	assign accept   = in_ch.valid && in_ch.ready;

	always_comb begin
		phase_d = phase_q;
		chan_d  = chan_q;
		count_d = count_q;
		index_d = index_q;
		r0      = '0;
		r1      = '0;
		n_res   = 2'd0;
		unique case (phase_q)
			PhHeader: begin
				chan_d  = w[31:24];
				phase_d = PhCount;
			end
			PhCount: begin
				count_d = {w[23:16], w[31:24]};
				index_d = '0;
				phase_d = PhData;
			end
			PhData: begin
				if (w == DataEndWord || index_q > {1'b0, count_q}) begin
					phase_d = PhFrame;
				end else begin
					r0.result_kind  = KindSample;
					r0.channel      = chan_q;
					r0.sample_index = index_q;
					r0.sample_value = s_lo;
					r0.sample_class = classify(s_lo, low_thr_q, high_thr_q);
					r1.result_kind  = KindSample;
					r1.channel      = chan_q;
					r1.sample_index = index_q + IndexW'(1);
					r1.sample_value = s_hi;
					r1.sample_class = classify(s_hi, low_thr_q, high_thr_q);
					r1.last         = 1'b1;
					index_d         = index_q + IndexW'(2);
					n_res           = 2'd2;
				end
			end
			PhEoe: begin
				if (w == DataEndWord) begin
					r0.result_kind = KindEoeOk;
				end else begin
					r0.result_kind = KindEoeBad;
					r0.bad_word    = w;
				end
				r0.last = 1'b1;
				n_res   = 2'd1;
				phase_d = PhFrame;
			end
			default: begin
				phase_d = (w == EventEndWord) ? PhEoe : PhHeader;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LowThrReset;
			high_thr_q <= HighThrReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegLowThr:  low_thr_q  <= cfg_data;
				RegHighThr: high_thr_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhFrame;
			chan_q  <= '0;
			count_q <= '0;
			index_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			chan_q  <= chan_d;
			count_q <= count_d;
			index_q <= index_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			have2_q     <= 1'b0;
		end else if (accept) begin
			out_valid_q <= (n_res != 2'd0);
			have2_q     <= (n_res == 2'd2);
		end else if (out_take) begin
			if (have2_q) begin
				have2_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res0_q <= r0;
			res1_q <= r1;
		end else if (out_take && have2_q) begin
			res0_q <= res1_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.result_kind  = res0_q.result_kind;
	assign out_ch.channel      = res0_q.channel;
	assign out_ch.sample_index = res0_q.sample_index;
	assign out_ch.sample_value = res0_q.sample_value;
	assign out_ch.sample_class = res0_q.sample_class;
	assign out_ch.bad_word     = res0_q.bad_word;
	assign out_ch.last         = res0_q.last;

endmodule
`default_nettype wire
